// ===== src/jesc_pkg.sv =====
// shared types, byte constants and helper functions for the json escaper
package jesc_pkg;

   localparam int QUEUE_DEPTH = 4;

   // how one unit of an entry is expanded on the output
   localparam logic [1:0] KIND_RAW  = 2'd0;
   localparam logic [1:0] KIND_ESC  = 2'd1;
   localparam logic [1:0] KIND_UESC = 2'd2;

   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0a;
   localparam logic [7:0] CHR_CR     = 8'h0d;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_BSLASH = 8'h5c;
   localparam logic [7:0] CHR_HEX_A  = 8'h57;  // 'a' minus ten
   localparam logic [7:0] CHR_N      = 8'h6e;
   localparam logic [7:0] CHR_R      = 8'h72;
   localparam logic [7:0] CHR_T      = 8'h74;
   localparam logic [7:0] CHR_U      = 8'h75;
   localparam logic [7:0] CHR_HIGH   = 8'h80;

   localparam logic [7:0] LEAD2_LO   = 8'hc2;
   localparam logic [7:0] LEAD2_HI   = 8'hdf;
   localparam logic [7:0] LEAD3_LO   = 8'he0;
   localparam logic [7:0] LEAD3_HI   = 8'hef;
   localparam logic [7:0] LEAD_ED    = 8'hed;
   localparam logic [7:0] LEAD4_LO   = 8'hf0;
   localparam logic [7:0] LEAD4_HI   = 8'hf4;
   localparam logic [7:0] CONT_LO    = 8'h80;
   localparam logic [7:0] CONT_HI    = 8'hbf;
   localparam logic [7:0] CONT_E0_LO = 8'ha0;
   localparam logic [7:0] CONT_ED_HI = 8'h9f;
   localparam logic [7:0] CONT_F0_LO = 8'h90;
   localparam logic [7:0] CONT_F4_HI = 8'h8f;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
   } unit_type;

   // one queue entry: up to four units, expanded in order
   typedef struct packed {
      unit_type [3:0] units;
      logic [1:0]     count_m1;
   } entry_type;

   typedef struct packed {
      logic     has_unit;
      logic     starts_hold;
      unit_type unit;
   } fresh_type;

   function automatic logic [1:0] lead_need(input logic [7:0] c);
      logic [1:0] n;
      n = 2'd0;
      if (c >= LEAD2_LO && c <= LEAD2_HI) n = 2'd1;
      else if (c >= LEAD3_LO && c <= LEAD3_HI) n = 2'd2;
      else if (c >= LEAD4_LO && c <= LEAD4_HI) n = 2'd3;
      return n;
   endfunction

   function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_LO;
      hi = CONT_HI;
      if (pos == 2'd1) begin
         if (lead == LEAD3_LO) lo = CONT_E0_LO;
         else if (lead == LEAD_ED) hi = CONT_ED_HI;
         else if (lead == LEAD4_LO) lo = CONT_F0_LO;
         else if (lead == LEAD4_HI) hi = CONT_F4_HI;
      end
      return (c >= lo) && (c <= hi);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? (CHR_ZERO + {4'd0, v}) : (CHR_HEX_A + {4'd0, v});
   endfunction

   // what a byte does when nothing is held
   function automatic fresh_type classify(input logic [7:0] c);
      fresh_type f;
      f.has_unit    = 1'b1;
      f.starts_hold = 1'b0;
      f.unit.data   = c;
      f.unit.kind   = KIND_RAW;
      if (c == CHR_NUL) begin
         f.has_unit = 1'b0;
      end else if (c == CHR_QUOTE || c == CHR_BSLASH) begin
         f.unit.kind = KIND_ESC;
      end else if (c == CHR_LF) begin
         f.unit.kind = KIND_ESC;
         f.unit.data = CHR_N;
      end else if (c == CHR_CR) begin
         f.unit.kind = KIND_ESC;
         f.unit.data = CHR_R;
      end else if (c == CHR_TAB) begin
         f.unit.kind = KIND_ESC;
         f.unit.data = CHR_T;
      end else if (c < CHR_SPACE) begin
         f.unit.kind = KIND_UESC;
      end else if (c < CHR_HIGH) begin
         f.unit.kind = KIND_RAW;
      end else if (lead_need(c) != 2'd0) begin
         f.has_unit    = 1'b0;
         f.starts_hold = 1'b1;
      end else begin
         f.unit.kind = KIND_UESC;
      end
      return f;
   endfunction

endpackage

// ===== src/jesc_front.sv =====
// front end: takes input bytes, tracks pending utf-8 sequences, builds queue entries
module jesc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                queue_full,
   output logic                push,
   output jesc_pkg::entry_type push_entry
);

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] cnt_ff, cnt_in;

   jesc_pkg::fresh_type cls;
   logic       accept;
   logic [1:0] need;
   logic       cont_good;
   logic       complete;
   logic       extend;
   logic       c_present;
   logic [2:0] n_units;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign cls       = jesc_pkg::classify(req_in_byte);
   assign need      = jesc_pkg::lead_need(held_ff[0]);

   assign cont_good = (cnt_ff != 2'd0) && (req_in_byte != jesc_pkg::CHR_NUL) &&
                      (need != 2'd0) && jesc_pkg::cont_ok(held_ff[0], cnt_ff, req_in_byte);
   assign complete  = cont_good && (cnt_ff == need);
   assign extend    = cont_good && (cnt_ff != need);
   // a failed sequence reissues the held bytes as escapes, then the current byte
   assign c_present = complete || (!cont_good && cls.has_unit);
   assign n_units   = {1'b0, cnt_ff} + {2'd0, c_present};

   always_comb begin
      push_entry          = '0;
      push_entry.count_m1 = 2'(n_units - 3'd1);
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < {1'b0, cnt_ff}) begin
            push_entry.units[i].data = held_ff[i];
            push_entry.units[i].kind = complete ? jesc_pkg::KIND_RAW : jesc_pkg::KIND_UESC;
         end else if (2'(i) == cnt_ff) begin
            if (complete) begin
               push_entry.units[i].data = req_in_byte;
               push_entry.units[i].kind = jesc_pkg::KIND_RAW;
            end else begin
               push_entry.units[i] = cls.unit;
            end
         end
      end
   end

   assign push = accept && !extend && (n_units != 3'd0);

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         if (extend) begin
            held_in[cnt_ff] = req_in_byte;
            cnt_in          = cnt_ff + 2'd1;
         end else if (complete) begin
            cnt_in = 2'd0;
         end else if (cls.starts_hold) begin
            held_in[0] = req_in_byte;
            cnt_in     = 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_held_lead_valid: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> need != 2'd0)
      else $error("held sequence without a valid lead byte");

   a_held_within_need: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= need || cnt_ff == 2'd0)
      else $error("more bytes held than the lead byte calls for");

endmodule

// ===== src/jesc_queue.sv =====
// short fifo of expansion entries between front and back end
module jesc_queue #(
   parameter int DEPTH = jesc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jesc_pkg::entry_type push_entry,
   input  logic                pop,
   output jesc_pkg::entry_type head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jesc_pkg::entry_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("entry pushed into a full queue");

endmodule

// ===== src/jesc_back.sv =====
// back end: expands queue entries into escaped output bytes, one per cycle while rsp_ready is high
module jesc_back (
   input  logic                clock,
   input  logic                reset,
   input  jesc_pkg::entry_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_run_last
);

   logic [1:0] unit_idx_ff, unit_idx_in;
   logic [2:0] sub_idx_ff, sub_idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;

   jesc_pkg::unit_type cur;
   logic       load;
   logic [7:0] cur_byte;
   logic       unit_end;
   logic       entry_end;

   assign cur  = head.units[unit_idx_ff];
   assign load = !empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cur_byte = cur.data;
      unit_end = 1'b1;
      unique case (cur.kind)
         jesc_pkg::KIND_ESC: begin
            cur_byte = (sub_idx_ff == 3'd0) ? jesc_pkg::CHR_BSLASH : cur.data;
            unit_end = (sub_idx_ff == 3'd1);
         end
         jesc_pkg::KIND_UESC: begin
            unit_end = (sub_idx_ff == 3'd5);
            unique case (sub_idx_ff)
               3'd0:    cur_byte = jesc_pkg::CHR_BSLASH;
               3'd1:    cur_byte = jesc_pkg::CHR_U;
               3'd2:    cur_byte = jesc_pkg::CHR_ZERO;
               3'd3:    cur_byte = jesc_pkg::CHR_ZERO;
               3'd4:    cur_byte = jesc_pkg::hex_digit(cur.data[7:4]);
               default: cur_byte = jesc_pkg::hex_digit(cur.data[3:0]);
            endcase
         end
         default: begin
            cur_byte = cur.data;
            unit_end = 1'b1;
         end
      endcase
   end

   assign entry_end = unit_end && (unit_idx_ff == head.count_m1);
   assign pop       = load && entry_end;

   always_comb begin
      unit_idx_in = unit_idx_ff;
      sub_idx_in  = sub_idx_ff;
      if (load) begin
         if (unit_end) begin
            sub_idx_in  = 3'd0;
            unit_idx_in = entry_end ? 2'd0 : unit_idx_ff + 2'd1;
         end else begin
            sub_idx_in = sub_idx_ff + 3'd1;
         end
      end
   end

   // output register lets the next byte load as soon as the current beat leaves
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= entry_end;
      end
      if (reset) begin
         unit_idx_ff  <= 2'd0;
         sub_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unit_idx_ff  <= unit_idx_in;
         sub_idx_ff   <= sub_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   a_unit_in_entry: assert property (@(posedge clock) disable iff (reset)
      !empty |-> unit_idx_ff <= head.count_m1)
      else $error("unit index past the end of the head entry");

   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      empty |-> (unit_idx_ff == 2'd0 && sub_idx_ff == 3'd0))
      else $error("expansion position left over with an empty queue");

endmodule

// ===== src/json_escape_utf8_validate_top.sv =====
// top level of the streaming json string escaper with utf-8 validation
// Takes one string byte per beat on req_ and gives the escaped string body one byte per
// beat on rsp_, with rsp_run_last marking the final byte caused by each input byte.
// Plain ASCII flows at one byte per cycle in and out while rsp_ready is high. The back end
// sends one output byte per cycle while rsp_ready is high, and a byte that expands gives
// two output bytes for a short escape, six for a \u00xx escape, up to twenty-four when a held
// four-byte sequence fails; bytes of a valid multi-byte sequence are held and then sent
// together with the final continuation. The front end accepts a byte every cycle until
// the QUEUE_DEPTH-entry queue between the two ends fills, which is what stalls input
// behind long expansions. A zero byte ends the string and flushes any held bytes.
module json_escape_utf8_validate_top #(
   parameter int QUEUE_DEPTH = jesc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   jesc_pkg::entry_type push_entry;
   jesc_pkg::entry_type head;
   logic                push;
   logic                pop;
   logic                empty;
   logic                full;

   jesc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .queue_full  (full),
      .push        (push),
      .push_entry  (push_entry)
   );

   jesc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   jesc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .empty        (empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the json string escaper with utf-8 validation
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 35;
   localparam int MAX_SHOWN    = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   // expected output beats as {run_last, out_byte}
   logic [8:0] escaped_q[$];
   logic [7:0] step_q[$];

   // predictor state
   logic [7:0] held_seq[0:2];
   int         held_cnt = 0;

   int err_count    = 0;
   int sent_count   = 0;
   int idle_cycles  = 0;
   int send_idle    = 0;
   int recv_stall   = 0;
   int hold_request = 0;
   int hold_left    = 0;

   json_escape_utf8_validate_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- predictor ----------------

   function automatic int seq_len(input logic [7:0] c);
      if (c >= 8'hc2 && c <= 8'hdf) return 1;
      if (c >= 8'he0 && c <= 8'hef) return 2;
      if (c >= 8'hf0 && c <= 8'hf4) return 3;
      return 0;
   endfunction

   function automatic logic cont_fits(input logic [7:0] lead, input int pos,
                                      input logic [7:0] c);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hbf;
      if (pos == 1) begin
         case (lead)
            8'he0: lo = 8'ha0;
            8'hed: hi = 8'h9f;
            8'hf0: lo = 8'h90;
            8'hf4: hi = 8'h8f;
            default: ;
         endcase
      end
      return c >= lo && c <= hi;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h61 + 8'(v) - 8'd10;
   endfunction

   task automatic emit_uesc(input logic [7:0] c);
      step_q.push_back(8'h5c);
      step_q.push_back(8'h75);
      step_q.push_back(8'h30);
      step_q.push_back(8'h30);
      step_q.push_back(hex_char(c[7:4]));
      step_q.push_back(hex_char(c[3:0]));
   endtask

   // a nonzero byte with nothing held
   task automatic fresh_byte(input logic [7:0] c);
      if (c == 8'h22 || c == 8'h5c) begin
         step_q.push_back(8'h5c);
         step_q.push_back(c);
      end else if (c == 8'h0a) begin
         step_q.push_back(8'h5c);
         step_q.push_back(8'h6e);
      end else if (c == 8'h0d) begin
         step_q.push_back(8'h5c);
         step_q.push_back(8'h72);
      end else if (c == 8'h09) begin
         step_q.push_back(8'h5c);
         step_q.push_back(8'h74);
      end else if (c < 8'h20) begin
         emit_uesc(c);
      end else if (c < 8'h80) begin
         step_q.push_back(c);
      end else if (seq_len(c) > 0) begin
         held_seq[0] = c;
         held_cnt = 1;
      end else begin
         emit_uesc(c);
      end
   endtask

   task automatic escape_predict(input logic [7:0] c);
      logic [7:0] lead;
      logic [7:0] rest[0:1];
      int         nrest;
      int         cnt;
      step_q.delete();
      if (held_cnt == 0) begin
         if (c != 8'h00) fresh_byte(c);
      end else begin
         lead = held_seq[0];
         cnt  = held_cnt;
         if (c != 8'h00 && cont_fits(lead, cnt, c)) begin
            if (cnt == seq_len(lead)) begin
               for (int i = 0; i < cnt; i++) step_q.push_back(held_seq[i]);
               step_q.push_back(c);
               held_cnt = 0;
            end else begin
               held_seq[cnt] = c;
               held_cnt = cnt + 1;
            end
         end else begin
            // failed sequence: lead escaped, the rest replayed as fresh bytes
            nrest = 0;
            for (int i = 1; i < cnt; i++) begin
               rest[nrest] = held_seq[i];
               nrest++;
            end
            held_cnt = 0;
            emit_uesc(lead);
            for (int i = 0; i < nrest; i++) fresh_byte(rest[i]);
            if (c != 8'h00) fresh_byte(c);
         end
      end
      foreach (step_q[i]) escaped_q.push_back({i == step_q.size() - 1, step_q[i]});
   endtask

   // ---------------- monitor, checker and watchdog ----------------

   always @(posedge clock) begin
      logic [8:0] want;
      if (!reset) begin
         if (req_valid && req_ready) escape_predict(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            if (escaped_q.size() == 0) begin
               err_count++;
               if (err_count <= MAX_SHOWN)
                  $display("unexpected beat: out_byte %h run_last %b",
                           rsp_out_byte, rsp_run_last);
            end else begin
               want = escaped_q.pop_front();
               if (rsp_out_byte !== want[7:0] || rsp_run_last !== want[8]) begin
                  err_count++;
                  if (err_count <= MAX_SHOWN)
                     $display("mismatch: out_byte exp %h got %h, run_last exp %b got %b",
                              want[7:0], rsp_out_byte, want[8], rsp_run_last);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off counted here
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic send_bytes(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      // let the last accepted beat be predicted before the queue is checked
      @(posedge clock);
      while (escaped_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_idling(input int snd, input int rcv);
      send_idle  = snd;
      recv_stall = rcv;
   endtask

   task automatic test_ascii_escapes();
      send_bytes('{8'h00, 8'h22, 8'h5c, 8'h0a, 8'h0d, 8'h09, 8'h01, 8'h1f,
                   8'h20, 8'h7e, 8'h7f, 8'h80, 8'hc1, 8'hf5, 8'hff});
      drain();
   endtask

   task automatic test_utf8_valid();
      send_bytes('{8'hc2, 8'h80, 8'hdf, 8'hbf, 8'he0, 8'ha0, 8'h80,
                   8'hed, 8'h9f, 8'hbf, 8'hf0, 8'h90, 8'h80, 8'h80,
                   8'hf4, 8'h8f, 8'hbf, 8'hbf});
      drain();
   endtask

   task automatic test_utf8_invalid();
      // overlong, surrogate, above the top code point, too-low after f0
      send_bytes('{8'he0, 8'h9f, 8'hed, 8'ha0, 8'hf4, 8'h90, 8'hf0, 8'h8f});
      // held bytes replayed, then a new lead, then ascii failing it
      send_bytes('{8'hf0, 8'h90, 8'h80, 8'hc2, 8'h41});
      // longest expansion: three held bytes and a control byte
      send_bytes('{8'hf0, 8'h90, 8'h80, 8'h01});
      // end of string while holding
      send_bytes('{8'hc2, 8'h00, 8'he0, 8'ha0, 8'h00});
      drain();
   endtask

   task automatic send_valid_seq();
      logic [7:0] lead;
      int         n;
      n = $urandom_range(1, 3);
      case (n)
         1: lead = 8'($urandom_range(8'hc2, 8'hdf));
         2: lead = 8'($urandom_range(8'he0, 8'hef));
         default: lead = 8'($urandom_range(8'hf0, 8'hf4));
      endcase
      send_byte(lead);
      for (int pos = 1; pos <= n; pos++) begin
         if (pos == 1 && lead == 8'he0) send_byte(8'($urandom_range(8'ha0, 8'hbf)));
         else if (pos == 1 && lead == 8'hed) send_byte(8'($urandom_range(8'h80, 8'h9f)));
         else if (pos == 1 && lead == 8'hf0) send_byte(8'($urandom_range(8'h90, 8'hbf)));
         else if (pos == 1 && lead == 8'hf4) send_byte(8'($urandom_range(8'h80, 8'h8f)));
         else send_byte(8'($urandom_range(8'h80, 8'hbf)));
      end
   endtask

   task automatic send_broken_seq();
      logic [7:0] lead;
      int         cut;
      lead = 8'($urandom_range(8'hc2, 8'hf4));
      send_byte(lead);
      cut = $urandom_range(0, seq_len(lead) - 1);
      for (int i = 0; i < cut; i++) send_byte(8'($urandom_range(8'h80, 8'hbf)));
      send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic test_random(input int snd, input int rcv);
      int target;
      int pick;
      set_idling(snd, rcv);
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         pick = $urandom_range(99);
         if (pick < 45) send_byte(8'($urandom_range(1, 8'h7f)));
         else if (pick < 75) send_valid_seq();
         else if (pick < 87) send_broken_seq();
         else if (pick < 95) send_byte(8'($urandom_range(0, 255)));
         else send_byte(8'h00);
      end
      drain();
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      hold_request = 300;
      // long expansions fill the queue while the receiver is held off
      for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(1, 8'h08)));
      send_bytes('{8'hf0, 8'h90, 8'h80, 8'h01, 8'h22, 8'h41});
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(0, 0);
      test_ascii_escapes();
      test_utf8_valid();
      test_utf8_invalid();
      test_random(0, 0);
      test_random(87, 0);
      test_random(0, 87);
      test_random(29, 29);
      test_backpressure();
      repeat (40) @(posedge clock);
      if (err_count == 0 && escaped_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
